### rtl/lla_pkg.sv
// ----------------------------------------------------------------------------
// lla_pkg: shared types and constants for the least-loaded bin assigner
// Load and weight widths, bin count limits, register indexes, cell control.
// ----------------------------------------------------------------------------
package lla_pkg;

  localparam int LOAD_W      = 32;
  localparam int WEIGHT_W    = 16;
  localparam int LIMIT_W     = 16;
  localparam int BINS_W      = 5;
  localparam int BIN_NUM_W   = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DEF_NUM_BINS = 16;
  localparam int MAX_BINS    = 64;
  localparam int CNT_W       = $clog2(MAX_BINS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_LIMIT = 2'd1;

  typedef logic [LOAD_W-1:0] load_t;

  typedef struct packed {
    logic                upd;
    logic                clr;
    logic [WEIGHT_W-1:0] weight;
  } lla_ctl_t;

endpackage

### rtl/lla_cell.sv
// ----------------------------------------------------------------------------
// lla_cell: one bin of the load chain
// Holds one bin load, folds it into the passing min/max token, adds a job
// weight with saturation when selected, clears at batch end.
// ----------------------------------------------------------------------------
module lla_cell #(
  parameter int CELL_IDX = 0,
  parameter int IW       = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lla_pkg::lla_ctl_t        ctl,
  input  logic [IW-1:0]            sel,
  input  logic [lla_pkg::CNT_W-1:0] cnt,
  input  lla_pkg::load_t           lo_i,
  input  lla_pkg::load_t           hi_i,
  input  logic [IW-1:0]            idx_i,
  output lla_pkg::load_t           lo_o,
  output lla_pkg::load_t           hi_o,
  output logic [IW-1:0]            idx_o
);
  import lla_pkg::*;

  load_t         load_r, load_nxt;
  load_t         lo_r, lo_nxt;
  load_t         hi_r, hi_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          active;
  logic [LOAD_W:0] sum;

  assign active = CNT_W'(CELL_IDX) < cnt;
  assign sum    = {1'b0, load_r} + (LOAD_W + 1)'(ctl.weight);

  always_comb begin
    lo_nxt  = lo_i;
    hi_nxt  = hi_i;
    idx_nxt = idx_i;
    if (active) begin
      if (load_r < lo_i) begin
        lo_nxt  = load_r;
        idx_nxt = IW'(CELL_IDX);
      end
      if (load_r > hi_i) begin
        hi_nxt = load_r;
      end
    end
  end

  always_comb begin
    load_nxt = load_r;
    if (ctl.clr) begin
      load_nxt = '0;
    end else if (ctl.upd && sel == IW'(CELL_IDX)) begin
      load_nxt = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
    end else begin
      load_r <= load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    idx_r <= idx_nxt;
  end

  assign lo_o  = lo_r;
  assign hi_o  = hi_r;
  assign idx_o = idx_r;

endmodule

### rtl/least_loaded_bin_assigner.sv
// ----------------------------------------------------------------------------
// least_loaded_bin_assigner: greedy least-loaded job placement
//
// Input channel: in_valid, in_stall, in_job_weight, in_batch_end. A beat is
// taken when in_valid is high and in_stall is low.
// Result channel: out_valid, out_stall, out_bin_number, out_verdict_valid,
// out_balanced_flag. One result beat per input beat, in order.
// Config channel: cfg_valid, cfg_ready, cfg_index, cfg_data; index 0 is the
// bin count, index 1 the balance limit. Write only while the block is idle.
// Each bin load sits in one cell of a chain; a min/max token walks the chain
// one cell per cycle. Each item scans the chain for the least-loaded bin and
// updates it; a batch's last job adds a second scan for the spread.
// One item is in flight at a time; the next beat is taken the cycle after
// the result has been loaded into the output register.
// Reset clears all loads, sets the bin count to NUM_BINS and the limit to 0.
// While out_stall is high the result holds; one more beat may be taken and
// worked, and it then waits until the output register frees.
// ----------------------------------------------------------------------------
module least_loaded_bin_assigner #(
  parameter int NUM_BINS = lla_pkg::DEF_NUM_BINS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lla_pkg::WEIGHT_W-1:0]   in_job_weight,
  input  logic                           in_batch_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lla_pkg::BIN_NUM_W-1:0]  out_bin_number,
  output logic                           out_verdict_valid,
  output logic                           out_balanced_flag,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lla_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lla_pkg::*;

  localparam int IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_VSCAN,
    ST_EMIT
  } state_t;

  state_t              state_r;
  logic [BINS_W-1:0]   bins_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic                last_r;
  logic [IW:0]         wait_r;
  logic [IW-1:0]       best_r;
  logic                flag_r;
  logic                out_valid_r;
  logic [BIN_NUM_W-1:0] out_bin_r;
  logic                out_verdict_r;
  logic                out_flag_r;

  logic [CNT_W-1:0]    cnt_eff;
  lla_ctl_t            ctl;
  logic                in_acc;
  logic                out_free;
  logic                scan_done;
  logic [IW:0]         bin_plus;
  load_t               spread;

  load_t         lo_c  [NUM_BINS+1];
  load_t         hi_c  [NUM_BINS+1];
  logic [IW-1:0] idx_c [NUM_BINS+1];

  always_comb begin
    if (bins_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (CNT_W'(bins_r) > CNT_W'(NUM_BINS)) begin
      cnt_eff = CNT_W'(NUM_BINS);
    end else begin
      cnt_eff = CNT_W'(bins_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_done = (wait_r == (IW + 1)'(NUM_BINS));
  assign cfg_ready = 1'b1;
  assign bin_plus  = {1'b0, best_r} + (IW + 1)'(1);
  assign spread    = hi_c[NUM_BINS] - lo_c[NUM_BINS];

  assign ctl.upd    = (state_r == ST_UPD);
  assign ctl.clr    = (state_r == ST_EMIT) && out_free && last_r;
  assign ctl.weight = weight_r;

  assign lo_c[0]  = '1;
  assign hi_c[0]  = '0;
  assign idx_c[0] = '0;

  for (genvar g = 0; g < NUM_BINS; g++) begin : g_cell
    lla_cell #(
      .CELL_IDX (g),
      .IW       (IW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sel   (best_r),
      .cnt   (cnt_eff),
      .lo_i  (lo_c[g]),
      .hi_i  (hi_c[g]),
      .idx_i (idx_c[g]),
      .lo_o  (lo_c[g+1]),
      .hi_o  (hi_c[g+1]),
      .idx_o (idx_c[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r  <= BINS_W'(NUM_BINS);
      limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BINS_IN_USE:   bins_r  <= cfg_data[BINS_W-1:0];
        REG_BALANCE_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wait_r      <= '0;
    end else begin
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            weight_r <= in_job_weight;
            last_r   <= in_batch_end;
            wait_r   <= '0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            best_r  <= idx_c[NUM_BINS];
            state_r <= ST_UPD;
          end else begin
            wait_r <= wait_r + (IW + 1)'(1);
          end
        end
        ST_UPD: begin
          wait_r  <= '0;
          flag_r  <= 1'b0;
          state_r <= last_r ? ST_VSCAN : ST_EMIT;
        end
        ST_VSCAN: begin
          if (scan_done) begin
            flag_r  <= (spread <= LOAD_W'(limit_r));
            state_r <= ST_EMIT;
          end else begin
            wait_r <= wait_r + (IW + 1)'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_bin_r     <= BIN_NUM_W'(bin_plus);
            out_verdict_r <= last_r;
            out_flag_r    <= flag_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bin_number    = out_bin_r;
  assign out_verdict_valid = out_verdict_r;
  assign out_balanced_flag = out_flag_r;

`ifndef ASSERT_OFF
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result beat raised outside emit");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (CNT_W'(best_r) < cnt_eff))
    else $error("chosen bin outside bins in use");

  a_flag_needs_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_verdict_r) |-> !out_flag_r)
    else $error("balanced flag without verdict");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN && wait_r == '0))
    else $error("accepted beat did not start a scan");
`endif

endmodule
